### src/kmsp_pkg.sv
`default_nettype none

package kmsp_pkg;

   localparam int NUM_CATHODES = 11;
   localparam int NUM_ANODES   = 6;
   localparam int BITMAP_W     = 61;
   localparam int PACKET_BYTES = 10;
   localparam int CATH_W       = 4;
   localparam int ANODE_W      = 6;
   localparam int BEAT_W       = $clog2(PACKET_BYTES);
   localparam int PKT_W        = 8 * PACKET_BYTES;

   localparam logic [BITMAP_W-1:0] BIT_ONE = BITMAP_W'(64'h0000000000000001);
   localparam logic [7:0]          BYTE_MASK = 8'hFF;

   typedef struct packed {
      logic [ANODE_W-1:0] anode_lines;
      logic               send_request;
   } req_payload_type;

   typedef struct packed {
      logic [CATH_W-1:0] next_cathode;
      logic              byte_valid;
      logic [7:0]        tx_byte;
      logic              last_byte;
   } rsp_payload_type;

   typedef struct packed {
      logic                scan_end;
      logic                send;
      logic [CATH_W-1:0]   next_cathode;
      logic [BITMAP_W-1:0] snapshot;
      logic [15:0]         counter;
   } scan_result_type;

   function automatic logic [BITMAP_W-1:0] anode_bits(input logic [CATH_W-1:0]  cath,
                                                       input logic [ANODE_W-1:0] lines);
      logic [BITMAP_W-1:0] mask;
      logic [6:0]          pos;
      mask = '0;
      for (int a = 0; a < NUM_ANODES; a++) begin
         pos = 7'(cath * NUM_ANODES) - 7'(a);
         if (!lines[a] && (pos < 7'(BITMAP_W))) begin
            mask = mask | (BIT_ONE << pos);
         end
      end
      return mask;
   endfunction

endpackage

`default_nettype wire

### src/kmsp_scan.sv
`default_nettype none

module kmsp_scan (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      accept,
   input  wire kmsp_pkg::req_payload_type req_payload,
   output kmsp_pkg::scan_result_type      result
);
   import kmsp_pkg::*;

   logic [CATH_W-1:0]   cathode_ff, cathode_in;
   logic [BITMAP_W-1:0] bitmap_ff, bitmap_in;
   logic [BITMAP_W-1:0] snapshot_ff, snapshot_in;
   logic [15:0]         counter_ff, counter_in;

   logic [CATH_W-1:0]   cath_eff;
   logic [BITMAP_W-1:0] bitmap_new;
   logic                scan_end;

   always_comb begin
      cath_eff = (cathode_ff >= CATH_W'(NUM_CATHODES)) ? '0 : cathode_ff;
      if (cath_eff == '0) begin
         bitmap_new = {{(BITMAP_W-1){1'b0}}, ~req_payload.anode_lines[0]};
      end else begin
         bitmap_new = bitmap_ff | anode_bits(cath_eff, req_payload.anode_lines);
      end
      scan_end = (cath_eff == CATH_W'(NUM_CATHODES - 1));

      result.scan_end     = scan_end;
      result.send         = scan_end && req_payload.send_request;
      result.next_cathode = scan_end ? '0 : cath_eff + CATH_W'(1);
      result.snapshot     = bitmap_new;
      result.counter      = counter_ff;

      cathode_in  = cathode_ff;
      bitmap_in   = bitmap_ff;
      snapshot_in = snapshot_ff;
      counter_in  = counter_ff;
      if (accept) begin
         cathode_in = result.next_cathode;
         if (scan_end) begin
            bitmap_in   = '0;
            snapshot_in = bitmap_new;
            if (req_payload.send_request) begin
               counter_in = counter_ff + 16'd1;
            end
         end else begin
            bitmap_in = bitmap_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cathode_ff  <= '0;
         bitmap_ff   <= '0;
         snapshot_ff <= '0;
         counter_ff  <= '0;
      end else begin
         cathode_ff  <= cathode_in;
         bitmap_ff   <= bitmap_in;
         snapshot_ff <= snapshot_in;
         counter_ff  <= counter_in;
      end
   end

`ifndef ASSERT_OFF
   a_cathode_range: assert property (@(posedge clock) disable iff (reset)
      cathode_ff < CATH_W'(NUM_CATHODES))
      else $error("cathode index out of range");

   a_wrap_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && scan_end) |=> (cathode_ff == '0 && bitmap_ff == '0))
      else $error("scan end did not wrap");

   a_counter_step: assert property (@(posedge clock) disable iff (reset)
      (accept && result.send) |=> (counter_ff == $past(counter_ff) + 16'd1))
      else $error("packet counter did not advance");
`endif

endmodule

`default_nettype wire

### src/kmsp_tx.sv
`default_nettype none

module kmsp_tx (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      load,
   input  wire kmsp_pkg::scan_result_type result,
   output logic                           load_ready,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output kmsp_pkg::rsp_payload_type      rsp_payload
);
   import kmsp_pkg::*;

   logic              valid_ff, valid_in;
   logic              bvalid_ff, bvalid_in;
   logic [BEAT_W-1:0] beats_ff, beats_in;
   logic [CATH_W-1:0] cath_ff, cath_in;
   logic [PKT_W-1:0]  data_ff, data_in;

   logic beat_done;
   logic last;

   always_comb begin
      last       = (beats_ff == '0);
      beat_done  = valid_ff && rsp_ready;
      load_ready = !valid_ff || (rsp_ready && last);

      valid_in  = valid_ff;
      bvalid_in = bvalid_ff;
      beats_in  = beats_ff;
      cath_in   = cath_ff;
      data_in   = data_ff;
      if (load) begin
         valid_in = 1'b1;
         cath_in  = result.next_cathode;
         if (result.send) begin
            bvalid_in = 1'b1;
            beats_in  = BEAT_W'(PACKET_BYTES - 1);
            data_in   = {(PKT_W-16)'(result.snapshot), result.counter[7:0], result.counter[15:8]};
         end else begin
            bvalid_in = 1'b0;
            beats_in  = '0;
            data_in   = '0;
         end
      end else if (beat_done) begin
         if (last) begin
            valid_in = 1'b0;
         end else begin
            beats_in = beats_ff - BEAT_W'(1);
            data_in  = data_ff >> 8;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         beats_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         beats_ff <= beats_in;
      end
      bvalid_ff <= bvalid_in;
      cath_ff   <= cath_in;
      data_ff   <= data_in;
   end

   assign rsp_valid                = valid_ff;
   assign rsp_payload.next_cathode = cath_ff;
   assign rsp_payload.byte_valid   = bvalid_ff;
   assign rsp_payload.tx_byte      = bvalid_ff ? (data_ff[7:0] & BYTE_MASK) : 8'd0;
   assign rsp_payload.last_byte    = last;

`ifndef ASSERT_OFF
   a_mid_packet_is_byte: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !last) |-> (bvalid_ff && cath_ff == '0))
      else $error("multi-beat result without packet byte");

   a_packet_continues: assert property (@(posedge clock) disable iff (reset)
      (beat_done && !last) |=> (valid_ff && beats_ff == $past(beats_ff) - BEAT_W'(1)))
      else $error("packet byte lost");

   a_no_load_mid_packet: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !last) |-> !load_ready)
      else $error("request taken during packet");
`endif

endmodule

`default_nettype wire

### src/key_matrix_scan_packetizer_top.sv
`default_nettype none
// a request's first result is valid in the cycle after the request is taken
// throughput: one request per cycle (single output register) while rsp_ready is high
// a scan-end request with send set gives ten result beats, one per packet byte
// req_ready stays low until the last result of the previous request is taken
// synchronous reset clears cathode index, bitmaps, packet counter and output valid
module key_matrix_scan_packetizer_top (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire kmsp_pkg::req_payload_type req_payload,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output kmsp_pkg::rsp_payload_type      rsp_payload
);
   import kmsp_pkg::*;

   scan_result_type result;
   logic            accept;

   assign accept = req_valid && req_ready;

   kmsp_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_payload (req_payload),
      .result      (result)
   );

   kmsp_tx u_tx (
      .clock       (clock),
      .reset       (reset),
      .load        (accept),
      .result      (result),
      .load_ready  (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

### test/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import kmsp_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int HOLD_CYCLES = 300;
   localparam int SCANS_PER_PHASE = 13;
   localparam int MAX_REPORTS = 20;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;

   req_payload_type pending_samples[$];
   rsp_payload_type expected_beats[$];

   logic [CATH_W-1:0]   model_cathode = '0;
   logic [BITMAP_W-1:0] model_scan = '0;
   logic [BITMAP_W-1:0] model_snapshot = '0;
   logic [15:0]         model_counter = '0;

   int send_idle_pct = 0;
   int rcv_idle_pct = 0;
   int hold_requests = 0;
   int hold_granted = 0;
   int hold_left = 0;
   int error_count = 0;
   int stall_cycles = 0;
   int gen_cathode = 0;

   key_matrix_scan_packetizer_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic rsp_payload_type make_beat(logic [CATH_W-1:0] cath, logic valid,
                                                 logic [7:0] data, logic last);
      rsp_payload_type beat;
      beat.next_cathode = cath;
      beat.byte_valid   = valid;
      beat.tx_byte      = data;
      beat.last_byte    = last;
      return beat;
   endfunction

   // advance the scan model by one cathode and queue the beats it produces
   task automatic scan_cathode(req_payload_type sample);
      int unsigned         cath;
      int unsigned         pos;
      logic [BITMAP_W-1:0] bits;
      cath = model_cathode;
      if (cath >= NUM_CATHODES) cath = 0;
      if (cath == 0) begin
         model_scan = '0;
         if (!sample.anode_lines[0]) model_scan[0] = 1'b1;
      end else begin
         for (int a = 0; a < NUM_ANODES; a++) begin
            pos = cath * NUM_ANODES - a;
            if (!sample.anode_lines[a] && pos < BITMAP_W) model_scan[pos] = 1'b1;
         end
      end
      if (cath + 1 < NUM_CATHODES) begin
         model_cathode = CATH_W'(cath + 1);
         expected_beats.push_back(make_beat(model_cathode, 1'b0, 8'h00, 1'b1));
      end else begin
         model_snapshot = model_scan;
         model_scan = '0;
         model_cathode = '0;
         if (!sample.send_request) begin
            expected_beats.push_back(make_beat('0, 1'b0, 8'h00, 1'b1));
         end else begin
            expected_beats.push_back(make_beat('0, 1'b1, model_counter[15:8], 1'b0));
            expected_beats.push_back(make_beat('0, 1'b1, model_counter[7:0], 1'b0));
            bits = model_snapshot;
            for (int k = 2; k < PACKET_BYTES; k++) begin
               expected_beats.push_back(make_beat('0, 1'b1, bits[7:0],
                                                  k == PACKET_BYTES - 1));
               bits = bits >> 8;
            end
            model_counter = model_counter + 16'd1;
         end
      end
   endtask

   task automatic queue_sample(logic [ANODE_W-1:0] lines, logic send);
      req_payload_type sample;
      sample.anode_lines  = lines;
      sample.send_request = send;
      pending_samples.push_back(sample);
      gen_cathode = (gen_cathode + 1) % NUM_CATHODES;
   endtask

   // full scans with random key patterns; send is noise except on the last cathode
   task automatic queue_scans(int count);
      logic [ANODE_W-1:0] lines;
      logic               send;
      for (int n = 0; n < count * NUM_CATHODES; n++) begin
         case ($urandom_range(7))
            0: lines = '0;
            1: lines = '1;
            default: lines = ANODE_W'($urandom_range(63));
         endcase
         if (gen_cathode == NUM_CATHODES - 1) send = ($urandom_range(9) < 6);
         else send = 1'($urandom_range(1));
         queue_sample(lines, send);
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_samples.size() > 0 || expected_beats.size() > 0 || req_valid);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_payload <= '0;
      end else begin
         if (req_valid && req_ready) scan_cathode(req_payload);
         if (!req_valid || req_ready) begin
            if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_payload <= pending_samples.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_beats.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_payload);
               $display("TEST FAILED");
               $finish;
            end else begin
               want = expected_beats.pop_front();
               if (rsp_payload.next_cathode !== want.next_cathode ||
                   rsp_payload.byte_valid !== want.byte_valid ||
                   rsp_payload.tx_byte !== want.tx_byte ||
                   rsp_payload.last_byte !== want.last_byte) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS)
                     $display("%0t: mismatch expected %0d/%b/%h/%b got %0d/%b/%h/%b",
                              $time, want.next_cathode, want.byte_valid, want.tx_byte,
                              want.last_byte, rsp_payload.next_cathode,
                              rsp_payload.byte_valid, rsp_payload.tx_byte,
                              rsp_payload.last_byte);
               end
            end
         end
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (hold_granted != hold_requests) begin
            hold_granted <= hold_granted + 1;
            hold_left <= HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles <= 0;
         end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      send_idle_pct = 20;
      rcv_idle_pct = 88;

      // every key closed, send asserted mid-scan and at scan end
      for (int n = 0; n < NUM_CATHODES; n++) queue_sample('0, 1'b1);
      // every key open, no send at scan end
      for (int n = 0; n < NUM_CATHODES; n++) queue_sample('1, 1'b0);
      queue_sample(6'h3E, 1'b1);
      queue_sample(6'h1F, 1'b0);
      queue_sample(6'h2A, 1'b1);
      wait_drained();

      queue_scans(SCANS_PER_PHASE);
      wait_drained();

      send_idle_pct = 88;
      rcv_idle_pct = 20;
      queue_scans(SCANS_PER_PHASE);
      wait_drained();

      send_idle_pct = 0;
      rcv_idle_pct = 0;
      hold_requests = hold_requests + 1;
      queue_scans(SCANS_PER_PHASE);
      wait_drained();

      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_beats.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
